### sv/mmwd_pkg.sv
// Shared types, codes and helper functions for the multi-module watchdog.
// Used by mmwd_period, mmwd_step and multi_module_watchdog; depends on nothing.
package mmwd_pkg;

    localparam int MASK_BITS = 32;
    localparam int ELAPSED_BITS = 14;
    localparam int DELAY_BITS = 16;
    localparam int COUNT_BITS = 6;
    localparam int INDEX_BITS = 3;
    localparam logic [DELAY_BITS-1:0] MIN_DELAY = 16'd16;
    localparam logic [DELAY_BITS-1:0] MAX_DELAY = 16'd8192;

    localparam logic [INDEX_BITS-1:0] REG_DELAY = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_COUNT = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_RESET_EN = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_IRQ_EN = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_RUNNING = 3'd4;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ALIVE = 2'd1,
        ACT_KICK  = 2'd2
    } action_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] module_count;
        logic                  reset_enable;
        logic                  interrupt_enable;
        logic                  running;
    } cfg_t;

    typedef struct packed {
        logic [MASK_BITS-1:0]    pending;
        logic [ELAPSED_BITS-1:0] elapsed;
    } wd_state_t;

    typedef struct packed {
        logic                 irq_fire;
        logic                 cpu_reset;
        logic                 kicked;
        logic [MASK_BITS-1:0] pending_mask;
    } result_t;

    function automatic logic [MASK_BITS-1:0] full_mask(input logic [COUNT_BITS-1:0] count);
        logic [MASK_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < MASK_BITS; i++)
        begin
            m[i] = (COUNT_BITS'(i) < count);
        end
        return m;
    endfunction

endpackage

### sv/mmwd_period.sv
// Timeout period from the requested delay: clamp and round up to 16 * 2^k ms.
// Depends on mmwd_pkg.
module mmwd_period
    import mmwd_pkg::*;
(
    input  logic [DELAY_BITS-1:0]   delay_ms,
    output logic [ELAPSED_BITS-1:0] period_ms
);

    logic [DELAY_BITS-1:0] clamped;
    logic [8:0]            steps;
    logic [3:0]            shift;

    always_comb
    begin
        if (delay_ms < MIN_DELAY)
            clamped = MIN_DELAY;
        else if (delay_ms > MAX_DELAY)
            clamped = MAX_DELAY;
        else
            clamped = delay_ms;
        steps = 9'((clamped - 16'd1) >> 4);
        shift = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (steps[i])
                shift = 4'(i + 1);
        end
        period_ms = ELAPSED_BITS'(MIN_DELAY) << shift;
    end

endmodule

### sv/mmwd_step.sv
// Next-state and result logic of the watchdog for one item.
// Depends on mmwd_pkg.
module mmwd_step
    import mmwd_pkg::*;
(
    input  logic [1:0]              action,
    input  logic [7:0]              module_id,
    input  cfg_t                    cfg,
    input  logic [ELAPSED_BITS-1:0] period_ms,
    input  wd_state_t               state_cur,
    output wd_state_t               state_next,
    output result_t                 result
);

    logic [MASK_BITS-1:0]    reload;
    logic [MASK_BITS-1:0]    cleared;
    logic [ELAPSED_BITS-1:0] count_up;

    always_comb
    begin
        reload = full_mask(cfg.module_count);
        cleared = state_cur.pending & ~(MASK_BITS'(1) << module_id[4:0]);
        count_up = state_cur.elapsed + ELAPSED_BITS'(1);
        state_next = state_cur;
        result = '0;
        case (action)
            ACT_TICK:
            begin
                if (cfg.running)
                begin
                    state_next.elapsed = count_up;
                    if (count_up >= period_ms)
                    begin
                        state_next.elapsed = '0;
                        result.irq_fire = cfg.interrupt_enable;
                        result.cpu_reset = cfg.reset_enable;
                        if (cfg.reset_enable)
                            state_next.pending = reload;
                    end
                end
            end
            ACT_ALIVE:
            begin
                if (module_id < 8'(cfg.module_count) && module_id < 8'(MASK_BITS))
                begin
                    state_next.pending = cleared;
                    if (cleared == '0)
                    begin
                        state_next.elapsed = '0;
                        state_next.pending = reload;
                        result.kicked = 1'b1;
                    end
                end
            end
            ACT_KICK:
            begin
                state_next.elapsed = '0;
                result.kicked = 1'b1;
            end
            default:
            begin
            end
        endcase
        result.pending_mask = state_next.pending;
    end

endmodule

### sv/multi_module_watchdog.sv
// Top level of the multi-module watchdog: configuration registers, input and
// result registers, and the watchdog state. Depends on mmwd_pkg, mmwd_period, mmwd_step.
//
// Items arrive on the input channel (in_valid, in_stall, action, module_id):
// a one millisecond tick, an alive report of one module, or a direct kick.
// Each item gives exactly one result item on the output channel (out_valid,
// out_stall, irq_fire, cpu_reset, kicked, pending_mask).
// An item is taken into an input register; once the output register is empty or
// not stalled, the result is written to the output register, raising out_valid,
// and the watchdog state is updated unless cfg_we is high in the same cycle.
// One item is accepted every cycle while the receiver does not stall; the state update
// is the only loop, so throughput is one item per clock. When the receiver stalls, the
// result register holds its item and the input register holds one more item, taking
// it if it was empty; then in_stall is raised. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle, as
// the block does not enforce this; register indexes beyond the list are ignored.
// Reset clears the channels, sets the delay to 16 ms and one module, clears
// the enables and the counter, and loads the pending mask with module zero.
module multi_module_watchdog
    import mmwd_pkg::*;
#(
    parameter int MAX_MODULES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [DELAY_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic [7:0]            module_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  irq_fire,
    output logic                  cpu_reset,
    output logic                  kicked,
    output logic [MASK_BITS-1:0]  pending_mask
);

    localparam int MODULE_LIMIT = (MAX_MODULES < MASK_BITS) ? MAX_MODULES : MASK_BITS;

    logic [DELAY_BITS-1:0]   delay_reg;
    cfg_t                    cfg_reg;
    wd_state_t               state_reg;
    wd_state_t               state_next;
    logic [ELAPSED_BITS-1:0] period_ms;

    logic                    in_valid_reg;
    logic [1:0]              action_reg;
    logic [7:0]              module_id_reg;
    logic                    out_valid_reg;
    result_t                 result_reg;
    result_t                 result_next;
    logic                    advance;
    logic [COUNT_BITS-1:0]   count_value;
    logic                    count_ok;

    mmwd_period u_period
    (
        .delay_ms  (delay_reg),
        .period_ms (period_ms)
    );

    mmwd_step u_step
    (
        .action     (action_reg),
        .module_id  (module_id_reg),
        .cfg        (cfg_reg),
        .period_ms  (period_ms),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign count_value = cfg_data[COUNT_BITS-1:0];
    assign count_ok = (count_value >= COUNT_BITS'(1))
                   && (count_value <= COUNT_BITS'(MODULE_LIMIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= MIN_DELAY;
            cfg_reg.module_count <= COUNT_BITS'(1);
            cfg_reg.reset_enable <= 1'b0;
            cfg_reg.interrupt_enable <= 1'b0;
            cfg_reg.running <= 1'b0;
            state_reg.pending <= MASK_BITS'(1);
            state_reg.elapsed <= '0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DELAY:
                        delay_reg <= cfg_data;
                    REG_COUNT:
                    begin
                        if (count_ok)
                        begin
                            cfg_reg.module_count <= count_value;
                            state_reg.pending <= full_mask(count_value);
                        end
                    end
                    REG_RESET_EN:
                        cfg_reg.reset_enable <= cfg_data[0];
                    REG_IRQ_EN:
                        cfg_reg.interrupt_enable <= cfg_data[0];
                    REG_RUNNING:
                    begin
                        if (cfg_data[0] != cfg_reg.running)
                            state_reg.elapsed <= '0;
                        cfg_reg.running <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end

            if (!in_stall)
                in_valid_reg <= in_valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg <= action;
            module_id_reg <= module_id;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign irq_fire = result_reg.irq_fire;
    assign cpu_reset = result_reg.cpu_reset;
    assign kicked = result_reg.kicked;
    assign pending_mask = result_reg.pending_mask;

endmodule
